// File: hdl/jtca_pkg.sv
// Package: constants, types and tables shared by the joint transform block.
`default_nettype none
package jtca_pkg;
    localparam int MAX_CHANNELS = 6;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int CH_W = 3;
    localparam int ANG_W = 16;
    localparam int ENT_W = 18;
    localparam int CW = 34;
    localparam logic signed [ENT_W-1:0] ONE_Q16 = 18'sd65536;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sh026DD3B6A;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;

    localparam logic [2:0] KIND_XROT = 3'd0;
    localparam logic [2:0] KIND_YROT = 3'd1;
    localparam logic [2:0] KIND_ZROT = 3'd2;

    localparam logic [2:0] REG_COUNT = 3'd0;
    localparam logic [2:0] REG_KINDS = 3'd1;
    localparam logic [2:0] REG_OFFX = 3'd2;
    localparam logic [2:0] REG_OFFY = 3'd3;
    localparam logic [2:0] REG_OFFZ = 3'd4;

    typedef logic signed [ENT_W-1:0] entry_t;

    typedef struct packed {
        logic                    start;
        logic signed [ANG_W-1:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic   done;
        entry_t sn;
        entry_t cs;
    } cordic_rsp_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0: v = 34'sh03243F6A8;  5'd1: v = 34'sh01DAC6705;
            5'd2: v = 34'sh00FADBAFC;  5'd3: v = 34'sh007F56EA6;
            5'd4: v = 34'sh003FEAB76;  5'd5: v = 34'sh001FFD55B;
            5'd6: v = 34'sh000FFFAAA;  5'd7: v = 34'sh0007FFF55;
            5'd8: v = 34'sh0003FFFEA;  5'd9: v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF; 5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF; 5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF; 5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF; 5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF; 5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF; 5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF; 5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F; 5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F; 5'd27: v = 34'sh000000008;
            5'd28: v = 34'sh000000004; 5'd29: v = 34'sh000000002;
            5'd30: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// File: hdl/joint_transform_from_channel_angles.sv
// Top level: joint transform from up to six channel angles.
//
// Input beats carry angle_0..angle_5 (signed Q3.13 radians) on a valid/ready
// channel; each accepted beat yields one output beat holding the nine rotation
// entries (Q1.16, saturated to plus or minus one) and the joint offset as the
// translation. The block takes one beat at a time: ready is low from
// acceptance until the result has been taken.
// Each rotation channel passes through the states CHAN, to pick the channel
// and start the CORDIC, WAIT, for its 16 iterations and the finished result,
// MUL, on the single shared multiplier (two products for each of six entries,
// one product a cycle), and NEXT, to step on. A channel of any other kind
// passes only through CHAN and NEXT. Ready rises in the cycle after the result
// is taken. The iterative CORDIC and the one multiplier set the beat rate. If
// the receiver stalls, the result holds on the output until taken, and no new
// beat is accepted. Reset returns the count register to 3, the kinds and
// offset registers to 0 and the state to idle; the datapath registers are not
// reset. The configuration port is APB with pready always high.
`default_nettype none
module joint_transform_from_channel_angles (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] angle_0,
    input  wire logic signed [15:0] angle_1,
    input  wire logic signed [15:0] angle_2,
    input  wire logic signed [15:0] angle_3,
    input  wire logic signed [15:0] angle_4,
    input  wire logic signed [15:0] angle_5,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [17:0]      r00,
    output logic signed [17:0]      r01,
    output logic signed [17:0]      r02,
    output logic signed [17:0]      r10,
    output logic signed [17:0]      r11,
    output logic signed [17:0]      r12,
    output logic signed [17:0]      r20,
    output logic signed [17:0]      r21,
    output logic signed [17:0]      r22,
    output logic signed [31:0]      trans_x,
    output logic signed [31:0]      trans_y,
    output logic signed [31:0]      trans_z
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHAN  = 6'b000010,
        S_WAIT  = 6'b000100,
        S_MUL   = 6'b001000,
        S_NEXT  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]         count_reg;
    logic [17:0]        kinds_reg;
    logic signed [31:0] offx_reg, offy_reg, offz_reg;

    logic signed [15:0] ang_reg [jtca_pkg::MAX_CHANNELS];
    jtca_pkg::entry_t   m_reg [3][3];
    logic [2:0]         ch_reg;
    logic [2:0]         nch_reg;
    logic [1:0]         row_reg;
    logic [1:0]         ph_reg;
    logic [1:0]         p_reg, q_reg;
    jtca_pkg::entry_t   sn_reg, cs_reg;
    logic signed [35:0] acc_reg;
    logic signed [35:0] prod;
    jtca_pkg::entry_t   ma, mb, res, vp_reg;
    logic [2:0]         kind;
    logic [2:0]         ch_idx;

    jtca_pkg::cordic_req_t creq;
    jtca_pkg::cordic_rsp_t crsp;

    logic wr;
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[4:2])
            jtca_pkg::REG_COUNT: prdata = {29'd0, count_reg};
            jtca_pkg::REG_KINDS: prdata = {14'd0, kinds_reg};
            jtca_pkg::REG_OFFX:  prdata = offx_reg;
            jtca_pkg::REG_OFFY:  prdata = offy_reg;
            jtca_pkg::REG_OFFZ:  prdata = offz_reg;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd3;
            kinds_reg <= '0;
            offx_reg  <= '0;
            offy_reg  <= '0;
            offz_reg  <= '0;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                jtca_pkg::REG_COUNT: count_reg <= pwdata[2:0];
                jtca_pkg::REG_KINDS: kinds_reg <= pwdata[17:0];
                jtca_pkg::REG_OFFX:  offx_reg  <= pwdata;
                jtca_pkg::REG_OFFY:  offy_reg  <= pwdata;
                jtca_pkg::REG_OFFZ:  offz_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    jtca_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    assign ch_idx = (ch_reg < 3'(jtca_pkg::MAX_CHANNELS)) ? ch_reg : 3'd0;
    assign kind   = kinds_reg[3*ch_idx +: 3];

    // Phase 0 forms c*p, phase 1 adds s*q; phase 2 forms c*q, phase 3 subtracts s*p.
    always_comb
    begin
        case (ph_reg)
            2'd0: begin ma = cs_reg; mb = m_reg[row_reg][p_reg]; end
            2'd1: begin ma = sn_reg; mb = m_reg[row_reg][q_reg]; end
            2'd2: begin ma = cs_reg; mb = m_reg[row_reg][q_reg]; end
            default: begin ma = sn_reg; mb = vp_reg; end
        endcase
        prod = 36'(ma * mb);
        begin
            logic signed [35:0] s, t;
            s = (ph_reg == 2'd3) ? acc_reg - prod : acc_reg + prod;
            t = (s + 36'sd32768) >>> 16;
            if (t > 36'sd65536)
                res = jtca_pkg::ONE_Q16;
            else if (t < -36'sd65536)
                res = -jtca_pkg::ONE_Q16;
            else
                res = t[17:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        creq.start = 1'b0;
        creq.angle = ang_reg[ch_idx];
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_CHAN;
            S_CHAN:
            begin
                if (ch_reg >= nch_reg)
                    state_next = S_OUT;
                else if (kind inside {jtca_pkg::KIND_XROT, jtca_pkg::KIND_YROT,
                                      jtca_pkg::KIND_ZROT})
                begin
                    creq.start = 1'b1;
                    state_next = S_WAIT;
                end
                else
                    state_next = S_NEXT;
            end
            S_WAIT: if (crsp.done) state_next = S_MUL;
            S_MUL:  if (row_reg == 2'd2 && ph_reg == 2'd3) state_next = S_NEXT;
            S_NEXT: state_next = S_CHAN;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            if (in_valid)
            begin
                ang_reg[0] <= angle_0; ang_reg[1] <= angle_1; ang_reg[2] <= angle_2;
                ang_reg[3] <= angle_3; ang_reg[4] <= angle_4; ang_reg[5] <= angle_5;
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        m_reg[r][c] <= (r == c) ? jtca_pkg::ONE_Q16 : '0;
                ch_reg  <= '0;
                nch_reg <= (count_reg > 3'(jtca_pkg::MAX_CHANNELS))
                           ? 3'(jtca_pkg::MAX_CHANNELS) : count_reg;
            end
            S_CHAN:
            begin
                case (kind)
                    jtca_pkg::KIND_XROT: begin p_reg <= 2'd1; q_reg <= 2'd2; end
                    jtca_pkg::KIND_YROT: begin p_reg <= 2'd2; q_reg <= 2'd0; end
                    default:             begin p_reg <= 2'd0; q_reg <= 2'd1; end
                endcase
                row_reg <= '0;
                ph_reg  <= '0;
            end
            S_WAIT:
            begin
                sn_reg <= crsp.sn;
                cs_reg <= crsp.cs;
            end
            S_MUL:
            begin
                ph_reg <= ph_reg + 1'b1;
                case (ph_reg)
                    2'd0: acc_reg <= prod;
                    2'd1:
                    begin
                        vp_reg <= m_reg[row_reg][p_reg];
                        m_reg[row_reg][p_reg] <= res;
                    end
                    2'd2: acc_reg <= prod;
                    default:
                    begin
                        m_reg[row_reg][q_reg] <= res;
                        row_reg <= row_reg + 1'b1;
                    end
                endcase
            end
            S_NEXT: ch_reg <= ch_reg + 1'b1;
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign r00 = m_reg[0][0]; assign r01 = m_reg[0][1]; assign r02 = m_reg[0][2];
    assign r10 = m_reg[1][0]; assign r11 = m_reg[1][1]; assign r12 = m_reg[1][2];
    assign r20 = m_reg[2][0]; assign r21 = m_reg[2][1]; assign r22 = m_reg[2][2];
    assign trans_x = offx_reg;
    assign trans_y = offy_reg;
    assign trans_z = offz_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(r00) && $stable(r22))
        else $error("result changed while stalled");
    a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
        crsp.done |-> state_reg == S_WAIT) else $error("stray cordic result");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second beat taken");
endmodule
`default_nettype wire

// File: hdl/jtca_cordic.sv
// Iterative CORDIC giving sine and cosine of a Q3.13 angle in saturated Q1.16.
`default_nettype none
module jtca_cordic (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire jtca_pkg::cordic_req_t req,
    output jtca_pkg::cordic_rsp_t     rsp
);
    localparam int CW = jtca_pkg::CW;

    logic                       busy_reg;
    logic [jtca_pkg::STEP_W-1:0] step_reg;
    logic                       flip_reg;
    logic signed [CW-1:0]       x_reg, y_reg, z_reg;
    logic                       done_reg;
    jtca_pkg::entry_t           sn_reg, cs_reg;

    logic signed [CW-1:0] z0, zr, dx, dy, xn, yn, fx, fy;
    logic                 f0;

    function automatic jtca_pkg::entry_t to_q16(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = (v + 34'sd8192) >>> 14;
        if (t > 34'sd65536)
            return jtca_pkg::ONE_Q16;
        else if (t < -34'sd65536)
            return -jtca_pkg::ONE_Q16;
        return t[jtca_pkg::ENT_W-1:0];
    endfunction

    always_comb
    begin
        z0 = {{(CW-jtca_pkg::ANG_W-17){req.angle[jtca_pkg::ANG_W-1]}}, req.angle, 17'd0};
        zr = z0;
        f0 = 1'b0;
        if (z0 > jtca_pkg::HALF_PI_Q30)
        begin
            zr = z0 - jtca_pkg::PI_Q30;
            f0 = 1'b1;
        end
        else if (z0 < -jtca_pkg::HALF_PI_Q30)
        begin
            zr = z0 + jtca_pkg::PI_Q30;
            f0 = 1'b1;
        end
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        xn = z_reg[CW-1] ? x_reg + dx : x_reg - dx;
        yn = z_reg[CW-1] ? y_reg - dy : y_reg + dy;
        fx = flip_reg ? -xn : xn;
        fy = flip_reg ? -yn : yn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                flip_reg <= f0;
                x_reg    <= jtca_pkg::GAIN_Q30;
                y_reg    <= '0;
                z_reg    <= zr;
            end
            else if (busy_reg)
            begin
                x_reg <= xn;
                y_reg <= yn;
                z_reg <= z_reg[CW-1] ? z_reg + jtca_pkg::atan_q30(5'(step_reg))
                                     : z_reg - jtca_pkg::atan_q30(5'(step_reg));
                if (32'(step_reg) == jtca_pkg::CORDIC_STEPS - 1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    cs_reg   <= to_q16(fx);
                    sn_reg   <= to_q16(fy);
                end
                else
                    step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sn   = sn_reg;
    assign rsp.cs   = cs_reg;
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the joint transform block: directed and random angles, kinds and offsets.
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic signed [15:0] ang [6];
    } angles_t;

    typedef struct {
        logic signed [17:0] rot [9];
        logic signed [31:0] tr [3];
    } pose_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] angle_0, angle_1, angle_2, angle_3, angle_4, angle_5;
    logic signed [17:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [31:0] trans_x, trans_y, trans_z;

    joint_transform_from_channel_angles dut (.*);

    // Predictor's own copy of the registers.
    logic [2:0] pr_count;
    logic [17:0] pr_kinds;
    logic signed [31:0] pr_off [3];

    angles_t pending_angles [$];
    pose_t expected_poses [$];
    int errors;
    int burst_left, gap_left, hold_left;
    bit long_hold_req;
    bit stim_done;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat_unit(longint v);
        if (v > 65536) return 65536;
        if (v < -65536) return -65536;
        return v;
    endfunction

    function automatic longint atan_entry(int i);
        longint tab [16] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                             64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                             64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                             64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
        return tab[i];
    endfunction

    task automatic sine_cosine(input logic signed [15:0] a, output longint sn,
                               output longint cs);
        longint x, y, z, dx, dy;
        bit flip;
        x = 64'h26DD3B6A;
        y = 0;
        flip = 0;
        z = longint'(a) * 131072;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < jtca_pkg::CORDIC_STEPS; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_entry(i);
            end else begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = sat_unit(floor_sh(x + 8192, 14));
        sn = sat_unit(floor_sh(y + 8192, 14));
    endtask

    task automatic predict_pose(input angles_t a);
        longint m [3][3];
        longint sn, cs, vp, vq;
        int n, kind, p, q;
        pose_t e;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r][c] = (r == c) ? 65536 : 0;
        n = (pr_count > jtca_pkg::MAX_CHANNELS) ? jtca_pkg::MAX_CHANNELS : pr_count;
        for (int ch = 0; ch < n; ch++) begin
            kind = (pr_kinds >> (3 * ch)) & 7;
            if (kind == jtca_pkg::KIND_XROT) begin p = 1; q = 2; end
            else if (kind == jtca_pkg::KIND_YROT) begin p = 2; q = 0; end
            else if (kind == jtca_pkg::KIND_ZROT) begin p = 0; q = 1; end
            else continue;
            sine_cosine(a.ang[ch], sn, cs);
            for (int r = 0; r < 3; r++) begin
                vp = m[r][p];
                vq = m[r][q];
                m[r][p] = sat_unit(floor_sh(cs * vp + sn * vq + 32768, 16));
                m[r][q] = sat_unit(floor_sh(cs * vq - sn * vp + 32768, 16));
            end
        end
        for (int i = 0; i < 9; i++)
            e.rot[i] = m[i / 3][i % 3];
        for (int i = 0; i < 3; i++)
            e.tr[i] = pr_off[i];
        expected_poses = {expected_poses, e};
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver: bursts with gaps; valid is held until the beat is taken.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predict_pose(pending_angles.pop_front());
            end
            if (!in_valid || in_ready) begin
                if (pending_angles.size() > 0 && gap_left == 0) begin
                    in_valid <= 1'b1;
                    angle_0 <= pending_angles[0].ang[0];
                    angle_1 <= pending_angles[0].ang[1];
                    angle_2 <= pending_angles[0].ang[2];
                    angle_3 <= pending_angles[0].ang[3];
                    angle_4 <= pending_angles[0].ang[4];
                    angle_5 <= pending_angles[0].ang[5];
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200);
                    end else
                        burst_left--;
                end else begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge clk) begin
        pose_t e;
        logic signed [17:0] got [9];
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
                if (expected_poses.size() == 0) begin
                    report_mismatch("beats pending", 1, 0);
                end else begin
                    e = expected_poses.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== e.rot[i])
                            report_mismatch($sformatf("r%0d%0d", i / 3, i % 3), got[i], e.rot[i]);
                    if (trans_x !== e.tr[0]) report_mismatch("trans_x", trans_x, e.tr[0]);
                    if (trans_y !== e.tr[1]) report_mismatch("trans_y", trans_y, e.tr[1]);
                    if (trans_z !== e.tr[2]) report_mismatch("trans_z", trans_z, e.tr[2]);
                end
            end
            if (long_hold_req) begin
                long_hold_req = 0;
                hold_left = 2000;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            jtca_pkg::REG_COUNT: pr_count = val[2:0];
            jtca_pkg::REG_KINDS: pr_kinds = val[17:0];
            jtca_pkg::REG_OFFX: pr_off[0] = val;
            jtca_pkg::REG_OFFY: pr_off[1] = val;
            jtca_pkg::REG_OFFZ: pr_off[2] = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_angles.size() > 0 || in_valid || expected_poses.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic angles_t random_angles(int mode);
        angles_t a;
        for (int i = 0; i < 6; i++)
            case (mode)
                0: a.ang[i] = $urandom;
                1: a.ang[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                default: a.ang[i] = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
            endcase
        return a;
    endfunction

    initial begin
        angles_t a;
        logic [17:0] kinds;
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; out_ready = 0;
        angle_0 = 0; angle_1 = 0; angle_2 = 0; angle_3 = 0; angle_4 = 0; angle_5 = 0;
        pr_count = 3; pr_kinds = '0; pr_off = '{0, 0, 0};
        errors = 0; burst_left = 0; gap_left = 0; hold_left = 0;
        long_hold_req = 0; stim_done = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, then angle extremes and boundaries.
        foreach (a.ang[i]) a.ang[i] = 0;
        pending_angles = {pending_angles, a};
        foreach (a.ang[i]) a.ang[i] = 16'sh7FFF;
        pending_angles = {pending_angles, a};
        foreach (a.ang[i]) a.ang[i] = 16'sh8000;
        pending_angles = {pending_angles, a};
        foreach (a.ang[i]) a.ang[i] = 16'sd12868;
        pending_angles = {pending_angles, a};
        foreach (a.ang[i]) a.ang[i] = -16'sd12869;
        pending_angles = {pending_angles, a};
        foreach (a.ang[i]) a.ang[i] = 16'sd25736;
        pending_angles = {pending_angles, a};
        wait_drained();

        // Every kind in some slot, counts 0 and 7 (beyond the maximum), offset extremes.
        write_reg(jtca_pkg::REG_COUNT, 3'd7);
        write_reg(jtca_pkg::REG_KINDS, {3'd1, 3'd2, 3'd0, 3'd2, 3'd1, 3'd0});
        write_reg(jtca_pkg::REG_OFFX, 32'h7FFFFFFF);
        write_reg(jtca_pkg::REG_OFFY, 32'h80000000);
        write_reg(jtca_pkg::REG_OFFZ, 32'hFFFFFFFF);
        for (int i = 0; i < 6; i++) pending_angles = {pending_angles, random_angles(i % 3)};
        wait_drained();
        write_reg(jtca_pkg::REG_KINDS, {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2});
        for (int i = 0; i < 3; i++) pending_angles = {pending_angles, random_angles(0)};
        wait_drained();
        write_reg(jtca_pkg::REG_COUNT, 3'd0);
        write_reg(jtca_pkg::REG_KINDS, 18'h3FFFF);
        pending_angles = {pending_angles, random_angles(0)};
        wait_drained();

        // Random phases with a long receiver hold-off in the first.
        for (int ph = 0; ph < 20; ph++) begin
            write_reg(jtca_pkg::REG_COUNT, $urandom_range(0, 7));
            kinds = '0;
            for (int c = 0; c < 6; c++)
                kinds[3 * c +: 3] = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 7)
                                                                 : $urandom_range(0, 2);
            write_reg(jtca_pkg::REG_KINDS, kinds);
            write_reg(jtca_pkg::REG_OFFX, $urandom);
            write_reg(jtca_pkg::REG_OFFY, $urandom);
            write_reg(jtca_pkg::REG_OFFZ, $urandom);
            for (int i = 0; i < 50; i++)
                pending_angles = {pending_angles,
                                  random_angles($urandom_range(0, 5) == 0 ? 1 :
                                                $urandom_range(0, 1) ? 0 : 2)};
            if (ph == 0)
                long_hold_req = 1;
            wait_drained();
        end
        stim_done = 1;
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
